@@ hdl/urpf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART receive packet framer package
// Shared widths, close reason codes, register indexes and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package urpf_pkg;

  localparam int STORE_DEPTH_DEF = 64;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 7;
  localparam int STAMP_W = 32;
  localparam int RSN_W   = 3;

  // close reasons, in priority order after the begin byte
  localparam logic [RSN_W-1:0] RSN_FRAME    = 3'd0;
  localparam logic [RSN_W-1:0] RSN_PARITY   = 3'd1;
  localparam logic [RSN_W-1:0] RSN_TIMEOUT  = 3'd2;
  localparam logic [RSN_W-1:0] RSN_END      = 3'd3;
  localparam logic [RSN_W-1:0] RSN_BEGIN    = 3'd4;
  localparam logic [RSN_W-1:0] RSN_OVERFLOW = 3'd5;
  localparam logic [RSN_W-1:0] RSN_LENGTH   = 3'd6;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_EN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_BYTE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_EN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 3'd4;

  typedef struct packed {
    logic capture;    // take the accepted beat into the item registers
    logic rsn_latch;  // latch the close reason
    logic rsn_begin;  // latched reason is the begin byte
    logic store;      // write the byte, latch the first stamp
    logic rd_en;      // read the store at the drain index
    logic load_out;   // move the read byte into the output register
  } cmd_t;

  typedef struct packed {
    logic begin_close;  // begin byte seen while bytes are held
    logic close_hit;    // a close reason applies and bytes are held
    logic out_free;     // output register can take a beat
    logic rd_last;      // drain index points at the final held byte
  } sts_t;

endpackage

@@ hdl/urpf_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART receive packet framer channels
// Receive event channel and packet byte channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface urpf_rx_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic        frame_error;
  logic        parity_error;
  logic        idle_event;
  logic [31:0] time_now;

  modport source (
    output valid, rx_byte, frame_error, parity_error, idle_event, time_now,
    input  ready
  );
  modport sink (
    input  valid, rx_byte, frame_error, parity_error, idle_event, time_now,
    output ready
  );
endinterface

interface urpf_pkt_if;
  logic        valid;
  logic        ready;
  logic [7:0]  packet_byte;
  logic        last_byte;
  logic [2:0]  close_reason;
  logic [6:0]  packet_length;
  logic [31:0] start_time;

  modport source (
    output valid, packet_byte, last_byte, close_reason, packet_length, start_time,
    input  ready
  );
  modport sink (
    input  valid, packet_byte, last_byte, close_reason, packet_length, start_time,
    output ready
  );
endinterface

@@ hdl/urpf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART receive packet framer controller
// Sequences one receive event: evaluate, drain on begin byte, store, check
// close, drain the closed packet one beat at a time.
// ----------------------------------------------------------------------------
module urpf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  urpf_pkg::sts_t  sts_i,
  output urpf_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_STORE = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_LD    = 3'd5;

  logic [2:0] state_q, state_d;
  logic       resume_q, resume_d;

  always_comb begin
    state_d  = state_q;
    resume_d = resume_q;
    cmd_o    = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        // a begin byte flushes what is held before it is stored
        if (sts_i.begin_close) begin
          cmd_o.rsn_latch = 1'b1;
          cmd_o.rsn_begin = 1'b1;
          resume_d        = 1'b1;
          state_d         = S_RD;
        end else begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.close_hit) begin
          cmd_o.rsn_latch = 1'b1;
          resume_d        = 1'b0;
          state_d         = S_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_LD;
      end
      S_LD: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (sts_i.rd_last) begin
            state_d = resume_q ? S_STORE : S_IDLE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      resume_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      resume_q <= resume_d;
    end
  end

endmodule

@@ hdl/urpf_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART receive packet framer datapath
// Configuration registers, item registers, byte store, fill count, first
// stamp, close reason logic and the output register.
// ----------------------------------------------------------------------------
module urpf_dp #(
  parameter int STORE_DEPTH = urpf_pkg::STORE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [urpf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [urpf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [urpf_pkg::BYTE_W-1:0]      rx_byte_i,
  input  logic                             frame_error_i,
  input  logic                             parity_error_i,
  input  logic                             idle_event_i,
  input  logic [urpf_pkg::STAMP_W-1:0]     time_now_i,
  input  urpf_pkg::cmd_t                   cmd_i,
  output urpf_pkg::sts_t                   sts_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [urpf_pkg::BYTE_W-1:0]      packet_byte_o,
  output logic                             last_byte_o,
  output logic [urpf_pkg::RSN_W-1:0]       close_reason_o,
  output logic [urpf_pkg::LEN_W-1:0]       packet_length_o,
  output logic [urpf_pkg::STAMP_W-1:0]     start_time_o
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int LW = (CW > urpf_pkg::LEN_W) ? CW : urpf_pkg::LEN_W;

  // configuration
  logic                          begin_en_q;
  logic [urpf_pkg::BYTE_W-1:0]   begin_byte_q;
  logic                          end_en_q;
  logic [urpf_pkg::BYTE_W-1:0]   end_byte_q;
  logic [urpf_pkg::LEN_W-1:0]    max_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      begin_en_q   <= 1'b0;
      begin_byte_q <= '0;
      end_en_q     <= 1'b0;
      end_byte_q   <= '0;
      max_len_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        urpf_pkg::CFG_BEGIN_EN:   begin_en_q   <= cfg_wdata_i[0];
        urpf_pkg::CFG_BEGIN_BYTE: begin_byte_q <= cfg_wdata_i;
        urpf_pkg::CFG_END_EN:     end_en_q     <= cfg_wdata_i[0];
        urpf_pkg::CFG_END_BYTE:   end_byte_q   <= cfg_wdata_i;
        urpf_pkg::CFG_MAX_LEN:    max_len_q    <= cfg_wdata_i[urpf_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // accepted receive event
  logic [urpf_pkg::BYTE_W-1:0]  byte_q;
  logic                         fe_q, pe_q, idle_q;
  logic [urpf_pkg::STAMP_W-1:0] now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      byte_q <= rx_byte_i;
      fe_q   <= frame_error_i;
      pe_q   <= parity_error_i;
      idle_q <= idle_event_i;
      now_q  <= time_now_i;
    end
  end

  // store state
  logic [CW-1:0]                fill_q, fill_d;
  logic [AW-1:0]                rd_idx_q, rd_idx_d;
  logic [urpf_pkg::STAMP_W-1:0] stamp_q;
  logic [urpf_pkg::RSN_W-1:0]   reason_q;
  logic [urpf_pkg::BYTE_W-1:0]  mem_q [STORE_DEPTH];
  logic [urpf_pkg::BYTE_W-1:0]  rdata_q;

  logic                         full, fill_nz, wr_en, rd_last;
  logic                         begin_hit, end_hit, len_hit;
  logic                         rsn_valid;
  logic [urpf_pkg::RSN_W-1:0]   rsn_c;

  assign full      = (fill_q == CW'(STORE_DEPTH));
  assign fill_nz   = (fill_q != '0);
  assign begin_hit = !idle_q && begin_en_q && (byte_q == begin_byte_q);
  assign end_hit   = !idle_q && end_en_q && (byte_q == end_byte_q);
  assign len_hit   = (max_len_q != '0) && (LW'(fill_q) >= LW'(max_len_q));
  assign wr_en     = cmd_i.store && !idle_q && !full;
  assign rd_last   = ((CW'(rd_idx_q) + CW'(1)) == fill_q);

  always_comb begin
    rsn_valid = 1'b1;
    rsn_c     = urpf_pkg::RSN_FRAME;
    if (fe_q)          rsn_c = urpf_pkg::RSN_FRAME;
    else if (pe_q)     rsn_c = urpf_pkg::RSN_PARITY;
    else if (idle_q)   rsn_c = urpf_pkg::RSN_TIMEOUT;
    else if (end_hit)  rsn_c = urpf_pkg::RSN_END;
    else if (full)     rsn_c = urpf_pkg::RSN_OVERFLOW;
    else if (len_hit)  rsn_c = urpf_pkg::RSN_LENGTH;
    else               rsn_valid = 1'b0;
  end

  always_comb begin
    fill_d   = fill_q;
    rd_idx_d = rd_idx_q;
    if (cmd_i.load_out) begin
      // drop the packet once its final beat leaves the store
      if (rd_last) begin
        fill_d   = '0;
        rd_idx_d = '0;
      end else begin
        rd_idx_d = rd_idx_q + AW'(1);
      end
    end else if (wr_en) begin
      fill_d = fill_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      rd_idx_q <= '0;
      stamp_q  <= '0;
    end else begin
      fill_q   <= fill_d;
      rd_idx_q <= rd_idx_d;
      if (cmd_i.store && !fill_nz) begin
        stamp_q <= now_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rsn_latch) begin
      reason_q <= cmd_i.rsn_begin ? urpf_pkg::RSN_BEGIN : rsn_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[fill_q[AW-1:0]] <= byte_q;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_idx_q];
    end
  end

  // output register
  logic                         out_valid_q;
  logic [urpf_pkg::BYTE_W-1:0]  out_byte_q;
  logic                         out_last_q;
  logic [urpf_pkg::RSN_W-1:0]   out_rsn_q;
  logic [urpf_pkg::LEN_W-1:0]   out_len_q;
  logic [urpf_pkg::STAMP_W-1:0] out_stamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_byte_q  <= rdata_q;
      out_last_q  <= rd_last;
      out_rsn_q   <= reason_q;
      out_len_q   <= urpf_pkg::LEN_W'(fill_q);
      out_stamp_q <= stamp_q;
    end
  end

  assign sts_o.begin_close = begin_hit && fill_nz;
  assign sts_o.close_hit   = rsn_valid && fill_nz;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;
  assign sts_o.rd_last     = rd_last;

  assign out_valid_o     = out_valid_q;
  assign packet_byte_o   = out_byte_q;
  assign last_byte_o     = out_last_q;
  assign close_reason_o  = out_rsn_q;
  assign packet_length_o = out_len_q;
  assign start_time_o    = out_stamp_q;

endmodule

@@ hdl/uart_rx_packet_framer_core.sv @@
`timescale 1ns / 1ps
// Sequence: an event that closes nothing passes evaluate, store and check;
//   one that closes a packet adds a store read, then an output load, per byte,
//   and a begin byte that flushes a held packet adds that drain before storing.
// Throughput: a new event is taken only when the last one and its drain are
//   done; the drain rests on the single store read port and output register.
// Reset: asynchronous, active low; clears the state, config, fill count and stamp.
// ----------------------------------------------------------------------------
// UART receive packet framer
// Collects receive events into packets and streams each closed packet out
// beat by beat with its close reason, length and start time.
// ----------------------------------------------------------------------------
module uart_rx_packet_framer_core #(
  parameter int STORE_DEPTH = urpf_pkg::STORE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [urpf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [urpf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  urpf_rx_if.sink                         in_ch,
  urpf_pkt_if.source                      out_ch
);

  urpf_pkg::cmd_t cmd;
  urpf_pkg::sts_t sts;
  logic           in_ready;

  urpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  urpf_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .rx_byte_i       (in_ch.rx_byte),
    .frame_error_i   (in_ch.frame_error),
    .parity_error_i  (in_ch.parity_error),
    .idle_event_i    (in_ch.idle_event),
    .time_now_i      (in_ch.time_now),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_ch.valid),
    .out_ready_i     (out_ch.ready),
    .packet_byte_o   (out_ch.packet_byte),
    .last_byte_o     (out_ch.last_byte),
    .close_reason_o  (out_ch.close_reason),
    .packet_length_o (out_ch.packet_length),
    .start_time_o    (out_ch.start_time)
  );

  assign in_ch.ready = in_ready;

  // one event at a time: ready drops right after a beat is taken
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while an event is in progress");

  // store write and drain read never share a cycle
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.store && cmd.rd_en))
    else $error("store write and read in the same cycle");

  // output load only into a free output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> sts.out_free)
    else $error("output register overwritten");

  // a store read is never followed directly by another read or a capture
  a_load_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en |=> !cmd.rd_en && !cmd.capture)
    else $error("drain sequence broken");

endmodule
